// ----- rtl/tlia_pkg.sv -----
// Shared types and constants of the two-level index allocator.
`default_nettype none

package tlia_pkg;

   // Geometry of the index space.
   localparam int NUM_GROUPS  = 16;
   localparam int SLOT_BITS   = 6;
   localparam int HANDLE_BITS = 32;

   localparam int SLOTS_PER_GROUP = 1 << SLOT_BITS;
   localparam int GROUP_BITS      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int TOTAL_SLOTS     = NUM_GROUPS << SLOT_BITS;
   localparam int SLOT_ADDR_BITS  = GROUP_BITS + SLOT_BITS;
   localparam int FILL_BITS       = SLOT_BITS + 1;
   localparam int INDEX_BITS      = 10;
   localparam int REQ_HANDLE_BITS = 32;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOT_USED = 2'd2
   } status_type;

   // Request modes.
   typedef enum logic {
      MODE_ALLOCATE = 1'b0,
      MODE_RELEASE  = 1'b1
   } mode_type;

   // One request as it crosses the input channel.
   typedef struct packed {
      mode_type                     mode;
      logic [REQ_HANDLE_BITS-1:0]   handle;
      logic [INDEX_BITS-1:0]        release_index;
   } req_type;

   // One result as it crosses the result channel.
   typedef struct packed {
      status_type              status;
      logic [INDEX_BITS-1:0]   given_index;
   } rsp_type;

   // One group's row in the occupancy memory: count of used slots and the used map.
   typedef struct packed {
      logic [FILL_BITS-1:0]         fill;
      logic [SLOTS_PER_GROUP-1:0]   used;
   } row_type;

endpackage

`default_nettype wire

// ----- rtl/two_level_index_allocator.sv -----
// Top level of the two-level index allocator: group rows in memory, read-modify-write.
//
// Usage:
//   A request is transferred at a rising clock edge where start is high and busy
//   is low. req_data.mode selects allocate (store req_data.handle at the lowest
//   free slot of the first group that is not nearly full) or release (free the
//   slot named by req_data.release_index).
//   Every request yields exactly one result on rsp_data, shown for one cycle
//   with rsp_strobe high; the receiver takes it in that cycle and cannot stall.
//   The result is registered as ST_RUN ends and is taken at the edge that
//   ends the cycle in which rsp_strobe shows it.
//   busy is high while the block is in ST_RUN, after the transfer; a new request is taken
//   again after ST_RUN, also in the cycle its predecessor's result is shown.
//   The busy state comes from the occupancy row of one group: it is read from
//   the row memory at the transfer edge and written back as ST_RUN ends.
//   Reset clears the row valid bits and sets every group's availability flag,
//   so every group reads as empty right after reset; no clearing pass.
//   The handle memory is written only and needs no reset.
`default_nettype none

module two_level_index_allocator (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire tlia_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output tlia_pkg::rsp_type      rsp_data
);

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   // Memories: one occupancy row per group, and the stored handles.
   tlia_pkg::row_type                     row_mem [tlia_pkg::NUM_GROUPS];
   logic [tlia_pkg::HANDLE_BITS-1:0]      handle_mem [tlia_pkg::TOTAL_SLOTS];

   // Control state.
   state_type                             state_ff, state_in;
   logic [tlia_pkg::NUM_GROUPS-1:0]       row_valid_ff;
   logic [tlia_pkg::NUM_GROUPS-1:0]       avail_ff;
   logic                                  rsp_strobe_ff;

   // Request context held over the read cycle.
   logic                                  row_valid_rd_ff;
   tlia_pkg::row_type                     row_rd_ff;
   tlia_pkg::mode_type                    mode_ff;
   logic [tlia_pkg::HANDLE_BITS-1:0]      handle_ff;
   logic [tlia_pkg::GROUP_BITS-1:0]       grp_ff;
   logic [tlia_pkg::SLOT_BITS-1:0]        slot_ff;
   logic                                  no_group_ff;
   tlia_pkg::rsp_type                     rsp_ff;

   // Accept-side signals.
   logic                                  accept;
   logic [tlia_pkg::GROUP_BITS-1:0]       alloc_grp;
   logic                                  alloc_found;
   logic [tlia_pkg::INDEX_BITS-1:0]       rel_grp_wide;
   logic [tlia_pkg::GROUP_BITS-1:0]       grp_sel;

   // Update-side signals.
   tlia_pkg::row_type                     row_cur;
   tlia_pkg::row_type                     row_new;
   logic [tlia_pkg::SLOTS_PER_GROUP-1:0]  free_onehot;
   logic [tlia_pkg::SLOT_BITS-1:0]        free_slot;
   logic                                  free_any;
   logic                                  alloc_ok;
   logic                                  rel_ok;
   logic                                  row_we;
   logic [tlia_pkg::SLOT_BITS-1:0]        slot_sel;
   tlia_pkg::rsp_type                     rsp_in;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff == ST_RUN);

   // First group that still has room below its top slot.
   always_comb begin
      alloc_grp   = '0;
      alloc_found = 1'b0;
      for (int g = tlia_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
         if (avail_ff[g]) begin
            alloc_grp   = tlia_pkg::GROUP_BITS'(g);
            alloc_found = 1'b1;
         end
      end
   end

   // Group part of a release index, checked against the number of groups.
   assign rel_grp_wide = req_data.release_index >> tlia_pkg::SLOT_BITS;

   always_comb begin
      if (req_data.mode == tlia_pkg::MODE_ALLOCATE) begin
         grp_sel = alloc_grp;
      end else begin
         grp_sel = tlia_pkg::GROUP_BITS'(rel_grp_wide);
      end
   end

   // Sequencer: the row is read at the transfer from ST_IDLE and written back in ST_RUN.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Capture the request and read the group's row.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff         <= req_data.mode;
         handle_ff       <= tlia_pkg::HANDLE_BITS'(req_data.handle);
         grp_ff          <= grp_sel;
         slot_ff         <= tlia_pkg::SLOT_BITS'(req_data.release_index);
         row_rd_ff       <= row_mem[grp_sel];
         row_valid_rd_ff <= row_valid_ff[grp_sel];
         if (req_data.mode == tlia_pkg::MODE_ALLOCATE) begin
            no_group_ff <= !alloc_found;
         end else begin
            no_group_ff <= (rel_grp_wide >= tlia_pkg::INDEX_BITS'(tlia_pkg::NUM_GROUPS));
         end
      end
   end

   // A row never written since reset reads as an empty group.
   assign row_cur = row_valid_rd_ff ? row_rd_ff : '0;

   // Lowest free slot of the row.
   assign free_onehot = ~row_cur.used & (row_cur.used + tlia_pkg::SLOTS_PER_GROUP'(1));
   assign free_any    = |(~row_cur.used);

   always_comb begin
      free_slot = '0;
      for (int s = 0; s < tlia_pkg::SLOTS_PER_GROUP; s++) begin
         if (free_onehot[s]) begin
            free_slot = free_slot | tlia_pkg::SLOT_BITS'(s);
         end
      end
   end

   // Modify the row and build the result.
   always_comb begin
      alloc_ok = (mode_ff == tlia_pkg::MODE_ALLOCATE) && !no_group_ff && free_any;
      rel_ok   = (mode_ff == tlia_pkg::MODE_RELEASE) && !no_group_ff
                 && row_cur.used[slot_ff] && (row_cur.fill != '0);
      row_we   = alloc_ok || rel_ok;
      slot_sel = alloc_ok ? free_slot : slot_ff;
      row_new  = row_cur;
      rsp_in   = '0;
      if (alloc_ok) begin
         row_new.used       = row_cur.used | free_onehot;
         row_new.fill       = row_cur.fill + tlia_pkg::FILL_BITS'(1);
         rsp_in.status      = tlia_pkg::STATUS_OK;
         rsp_in.given_index = tlia_pkg::INDEX_BITS'({grp_ff, free_slot});
      end else if (rel_ok) begin
         row_new.used[slot_ff] = 1'b0;
         row_new.fill          = row_cur.fill - tlia_pkg::FILL_BITS'(1);
         rsp_in.status         = tlia_pkg::STATUS_OK;
      end else if (mode_ff == tlia_pkg::MODE_ALLOCATE) begin
         rsp_in.status = tlia_pkg::STATUS_FULL;
      end else begin
         rsp_in.status = tlia_pkg::STATUS_NOT_USED;
      end
   end

   // Write back the row and, on an allocate, the handle.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_RUN) && row_we) begin
         row_mem[grp_ff] <= row_new;
      end
      if ((state_ff == ST_RUN) && alloc_ok) begin
         handle_mem[{grp_ff, slot_sel}] <= handle_ff;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (state_ff == ST_RUN) begin
         rsp_ff <= rsp_in;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_valid_ff  <= '0;
         avail_ff      <= '1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_RUN);
         if ((state_ff == ST_RUN) && row_we) begin
            row_valid_ff[grp_ff] <= 1'b1;
            avail_ff[grp_ff]     <=
               (row_new.fill < tlia_pkg::FILL_BITS'(tlia_pkg::SLOTS_PER_GROUP - 1));
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ----- tb/tb_two_level_index_allocator.sv -----
// Self-checking testbench for the two-level index allocator with a scoreboard class.
`timescale 1ns / 100ps

module tb_two_level_index_allocator;

   localparam int STALL_LIMIT = 2000;
   localparam int SLOT_MASK   = tlia_pkg::SLOTS_PER_GROUP - 1;

   // Tracks slot occupancy and holds the results still owed by the block.
   class allocator_scoreboard;
      bit                slot_used [tlia_pkg::TOTAL_SLOTS];
      int unsigned       group_fill [tlia_pkg::NUM_GROUPS];
      tlia_pkg::rsp_type pending_results [$];
      int unsigned       failures;

      function new();
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         foreach (group_fill[i]) group_fill[i] = 0;
         failures = 0;
      endfunction

      // Counts a failure; only the first ten are described.
      function void report_failure(string what);
         failures++;
         if (failures <= 10) begin
            $display("ERROR at %0t: %s", $realtime, what);
         end
      endfunction

      // True when no group can take another allocation.
      function bit is_full();
         foreach (group_fill[g]) begin
            if (group_fill[g] < SLOT_MASK) begin
               return 1'b0;
            end
         end
         return 1'b1;
      endfunction

      // Returns a slot in use, searched from a random point, or any index if none is used.
      function logic [tlia_pkg::INDEX_BITS-1:0] pick_used_index();
         int unsigned start_at;
         int unsigned idx;
         start_at = $urandom_range(tlia_pkg::TOTAL_SLOTS - 1);
         for (int k = 0; k < tlia_pkg::TOTAL_SLOTS; k++) begin
            idx = (start_at + k) % tlia_pkg::TOTAL_SLOTS;
            if (slot_used[idx]) begin
               return idx[tlia_pkg::INDEX_BITS-1:0];
            end
         end
         return tlia_pkg::INDEX_BITS'($urandom_range((1 << tlia_pkg::INDEX_BITS) - 1));
      endfunction

      // Applies one accepted request to the occupancy state and queues its result.
      function void note_request(tlia_pkg::req_type r);
         tlia_pkg::rsp_type predicted;
         int unsigned       g;
         int unsigned       s;
         predicted.status      = tlia_pkg::STATUS_FULL;
         predicted.given_index = '0;
         if (r.mode == tlia_pkg::MODE_ALLOCATE) begin
            for (g = 0; g < tlia_pkg::NUM_GROUPS; g++) begin
               if (group_fill[g] < SLOT_MASK) break;
            end
            if (g < tlia_pkg::NUM_GROUPS) begin
               for (s = 0; s < tlia_pkg::SLOTS_PER_GROUP; s++) begin
                  if (!slot_used[g * tlia_pkg::SLOTS_PER_GROUP + s]) break;
               end
               if (s < tlia_pkg::SLOTS_PER_GROUP) begin
                  slot_used[g * tlia_pkg::SLOTS_PER_GROUP + s] = 1'b1;
                  group_fill[g]++;
                  predicted.status      = tlia_pkg::STATUS_OK;
                  predicted.given_index =
                     tlia_pkg::INDEX_BITS'(g * tlia_pkg::SLOTS_PER_GROUP + s);
               end
            end
         end else begin
            g = 32'(r.release_index) >> tlia_pkg::SLOT_BITS;
            s = 32'(r.release_index) & SLOT_MASK;
            predicted.status = tlia_pkg::STATUS_NOT_USED;
            if (g < tlia_pkg::NUM_GROUPS) begin
               if (slot_used[g * tlia_pkg::SLOTS_PER_GROUP + s] && group_fill[g] != 0) begin
                  slot_used[g * tlia_pkg::SLOTS_PER_GROUP + s] = 1'b0;
                  group_fill[g]--;
                  predicted.status = tlia_pkg::STATUS_OK;
               end
            end
         end
         pending_results.push_back(predicted);
      endfunction

      // Compares one result with the oldest outstanding prediction.
      function void check_result(tlia_pkg::rsp_type got);
         tlia_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            report_failure($sformatf("result with nothing outstanding: status %0d index %0d",
                                     got.status, got.given_index));
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.given_index !== want.given_index) begin
            report_failure($sformatf("status exp %0d got %0d, index exp %0d got %0d",
                                     want.status, got.status,
                                     want.given_index, got.given_index));
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   tlia_pkg::req_type req_data;
   logic              rsp_strobe;
   tlia_pkg::rsp_type rsp_data;

   allocator_scoreboard sb;
   int unsigned         quiet_cycles;

   two_level_index_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every result is taken in the cycle it is shown.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_result(rsp_data);
      end
   end

   // Ends the run if neither a request nor a result transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic tlia_pkg::req_type make_req(tlia_pkg::mode_type m,
                                                  logic [tlia_pkg::REQ_HANDLE_BITS-1:0] h,
                                                  logic [tlia_pkg::INDEX_BITS-1:0] idx);
      tlia_pkg::req_type r;
      r.mode          = m;
      r.handle        = h;
      r.release_index = idx;
      return r;
   endfunction

   // Drives one request after a random gap and returns at its transfer edge.
   // start stays high on return so back-to-back requests follow without a gap.
   task automatic send_request(tlia_pkg::req_type r, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(r);
   endtask

   // Random request with random content; most releases name a slot in use.
   task automatic send_random(int alloc_pct, int idle_pct);
      tlia_pkg::req_type r;
      r.handle        = $urandom;
      r.release_index =
         tlia_pkg::INDEX_BITS'($urandom_range((1 << tlia_pkg::INDEX_BITS) - 1));
      if ($urandom_range(99) < alloc_pct) begin
         r.mode = tlia_pkg::MODE_ALLOCATE;
      end else begin
         r.mode = tlia_pkg::MODE_RELEASE;
         if ($urandom_range(99) < 80) begin
            r.release_index = sb.pick_used_index();
         end
      end
      send_request(r, idle_pct);
   endtask

   // Holds off new requests until every outstanding result has arrived.
   task automatic wait_for_results();
      start <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      sb       = new();
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: handle extremes, reuse of the lowest free slot,
      // releases of free slots, the top index, and a group emptied completely.
      send_request(make_req(tlia_pkg::MODE_ALLOCATE, 32'h0000_0000, 10'h000), 16);
      send_request(make_req(tlia_pkg::MODE_ALLOCATE, 32'hFFFF_FFFF, 10'h3FF), 16);
      send_request(make_req(tlia_pkg::MODE_ALLOCATE, 32'hA5A5_A5A5, 10'h155), 16);
      send_request(make_req(tlia_pkg::MODE_RELEASE, 32'hFFFF_FFFF, 10'd1), 16);
      send_request(make_req(tlia_pkg::MODE_RELEASE, 32'h0000_0000, 10'd1), 16);
      send_request(make_req(tlia_pkg::MODE_ALLOCATE, 32'h5A5A_5A5A, 10'h2AA), 16);
      send_request(make_req(tlia_pkg::MODE_RELEASE, 32'h1234_5678, 10'h3FF), 16);
      send_request(make_req(tlia_pkg::MODE_RELEASE, 32'h0000_0000, 10'd63), 16);
      send_request(make_req(tlia_pkg::MODE_RELEASE, 32'h0000_0000, 10'd0), 16);
      send_request(make_req(tlia_pkg::MODE_RELEASE, 32'h0000_0000, 10'd2), 16);
      send_request(make_req(tlia_pkg::MODE_RELEASE, 32'h0000_0000, 10'd1), 16);
      send_request(make_req(tlia_pkg::MODE_RELEASE, 32'h0000_0000, 10'd0), 16);
      send_request(make_req(tlia_pkg::MODE_ALLOCATE, 32'h8000_0001, 10'h000), 16);
      send_request(make_req(tlia_pkg::MODE_RELEASE, 32'hFFFF_FFFF, 10'h040), 16);
      send_request(make_req(tlia_pkg::MODE_RELEASE, 32'h0000_0000, 10'h000), 16);

      // Light idling with a mix of allocations (60 percent) and releases.
      for (int i = 0; i < 40; i++) begin
         send_random(60, 16);
      end
      wait_for_results();

      // Heavy idling: fill every group until allocations report full,
      // then churn around the full point.
      while (!sb.is_full()) begin
         send_random(100, 55);
      end
      for (int i = 0; i < 5; i++) begin
         send_request(make_req(tlia_pkg::MODE_ALLOCATE, $urandom,
                               tlia_pkg::INDEX_BITS'($urandom)), 55);
      end
      for (int i = 0; i < 40; i++) begin
         send_random(50, 55);
      end

      // No idling: drain some slots, then a mixed stretch.
      for (int i = 0; i < 50; i++) begin
         send_random(25, 0);
      end
      for (int i = 0; i < 40; i++) begin
         send_random(55, 0);
      end

      wait_for_results();
      repeat (4) @(posedge clock);
      if (sb.pending_results.size() != 0) begin
         sb.report_failure("results still outstanding at the end");
      end
      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
